// ----- rtl/core/servo_reply_frame_parser_core_defines.svh -----
// Assertion macros used by the servo reply parser checker.
`ifndef SERVO_REPLY_FRAME_PARSER_CORE_DEFINES_SVH
`define SERVO_REPLY_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRFP_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("srfp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRFP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("srfp check failed");

`endif

// ----- rtl/core/srfp_pkg.sv -----
// Types and constants shared by the servo reply frame parser modules.
`default_nettype none

package srfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_BROADCAST_ID  = 3'd2,
    CFG_MAX_LENGTH    = 3'd3,
    CFG_MAX_COMMAND   = 3'd4
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd255;
  localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd255;
  localparam logic [BYTE_W-1:0] RST_BROADCAST_ID  = 8'd254;
  localparam logic [LEN_W-1:0]  RST_MAX_LENGTH    = 6'd34;
  localparam logic [BYTE_W-1:0] RST_MAX_COMMAND   = 8'd130;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_id;
    logic load_len;
    logic load_cmd;
    logic store_param;
    logic start_emit;
    logic emit_load;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hdr1_ok;
    logic hdr2_ok;
    logic id_ok;
    logic len_ok;
    logic cmd_ok;
    logic has_params;
    logic params_done;
    logic sum_ok;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/srfp_ctrl.sv -----
// Frame parsing and result sequencing state machine.
`default_nettype none

module srfp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  srfp_pkg::dp_status_t    status_i,
  output srfp_pkg::ctrl_cmd_t     cmd_o
);
  import srfp_pkg::*;

  typedef enum logic [3:0] {
    ST_HEAD1,
    ST_HEAD2,
    ST_ID,
    ST_LEN,
    ST_CMD,
    ST_PARAM,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e state_q, state_d;
  logic   byte_state;
  logic   accept;

  assign byte_state = (state_q != ST_EMIT_RD) && (state_q != ST_EMIT_LD);
  assign in_stall_o = !byte_state;
  assign accept     = in_valid_i && byte_state;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HEAD1: begin
        if (accept && status_i.hdr1_ok) state_d = ST_HEAD2;
      end
      ST_HEAD2: begin
        if (accept) state_d = status_i.hdr2_ok ? ST_ID : ST_HEAD1;
      end
      ST_ID: begin
        if (accept) begin
          cmd_o.load_id = status_i.id_ok;
          state_d       = status_i.id_ok ? ST_LEN : ST_HEAD1;
        end
      end
      ST_LEN: begin
        if (accept) begin
          cmd_o.load_len = status_i.len_ok;
          state_d        = status_i.len_ok ? ST_CMD : ST_HEAD1;
        end
      end
      ST_CMD: begin
        if (accept) begin
          cmd_o.load_cmd = status_i.cmd_ok;
          if (!status_i.cmd_ok)         state_d = ST_HEAD1;
          else if (status_i.has_params) state_d = ST_PARAM;
          else                          state_d = ST_CHECK;
        end
      end
      ST_PARAM: begin
        if (accept) begin
          cmd_o.store_param = 1'b1;
          if (status_i.params_done) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (accept) begin
          cmd_o.start_emit = status_i.sum_ok;
          if (!status_i.sum_ok)         state_d = ST_HEAD1;
          else if (status_i.has_params) state_d = ST_EMIT_RD;
          else                          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_RD: begin
        // store read data lands at the end of this cycle
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = status_i.emit_last ? ST_HEAD1 : ST_EMIT_RD;
        end
      end
      default: state_d = ST_HEAD1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEAD1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/srfp_dp.sv -----
// Datapath: config registers, field checks, checksum, parameter store, output register.
`default_nettype none

module srfp_dp #(
  parameter int unsigned MAX_PARAMS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [srfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [srfp_pkg::BYTE_W-1:0]     cfg_wdata_i,
  input  wire logic [srfp_pkg::BYTE_W-1:0]     rx_byte_i,
  input  srfp_pkg::ctrl_cmd_t                  cmd_i,
  output srfp_pkg::dp_status_t                 status_o,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output logic [srfp_pkg::BYTE_W-1:0]          src_id_o,
  output logic [srfp_pkg::BYTE_W-1:0]          status_byte_o,
  output logic [srfp_pkg::LEN_W-1:0]           param_count_o,
  output logic                                 has_param_o,
  output logic [srfp_pkg::IDX_OUT_W-1:0]       param_index_o,
  output logic [srfp_pkg::BYTE_W-1:0]          param_value_o,
  output logic                                 last_o
);
  import srfp_pkg::*;

  // Parameter count is capped by both MAX_PARAMS and the 32-entry frame limit.
  localparam int unsigned STORE_DEPTH = (MAX_PARAMS < 32) ? MAX_PARAMS : 32;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [BYTE_W-1:0] LEN_CAP = BYTE_W'(STORE_DEPTH + 2);

  logic [BYTE_W-1:0] header_first_q, header_second_q, broadcast_id_q, max_command_q;
  logic [LEN_W-1:0]  max_length_q;

  logic [BYTE_W-1:0] frame_id_q, frame_status_q, running_sum_q;
  logic [LEN_W-1:0]  frame_length_q, param_counter_q, emit_idx_q;

  logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  logic              out_valid_q;
  logic [LEN_W-1:0]  count_w;
  logic              has_params;

  assign count_w    = frame_length_q - LEN_W'(2);
  assign has_params = frame_length_q > LEN_W'(2);

  always_comb begin
    status_o             = '0;
    status_o.hdr1_ok     = rx_byte_i == header_first_q;
    status_o.hdr2_ok     = rx_byte_i == header_second_q;
    status_o.id_ok       = rx_byte_i <= broadcast_id_q;
    status_o.len_ok      = (rx_byte_i >= BYTE_W'(2)) &&
                           (rx_byte_i <= {{(BYTE_W-LEN_W){1'b0}}, max_length_q}) &&
                           (rx_byte_i <= LEN_CAP);
    status_o.cmd_ok      = rx_byte_i <= max_command_q;
    status_o.has_params  = has_params;
    status_o.params_done = (param_counter_q + LEN_W'(1)) >= count_w;
    status_o.sum_ok      = rx_byte_i == ~running_sum_q;
    status_o.out_free    = !out_valid_q || !out_stall_i;
    status_o.emit_last   = !has_params || ((emit_idx_q + LEN_W'(1)) == count_w);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q  <= RST_HEADER_FIRST;
      header_second_q <= RST_HEADER_SECOND;
      broadcast_id_q  <= RST_BROADCAST_ID;
      max_length_q    <= RST_MAX_LENGTH;
      max_command_q   <= RST_MAX_COMMAND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER_FIRST:  header_first_q  <= cfg_wdata_i;
        CFG_HEADER_SECOND: header_second_q <= cfg_wdata_i;
        CFG_BROADCAST_ID:  broadcast_id_q  <= cfg_wdata_i;
        CFG_MAX_LENGTH:    max_length_q    <= cfg_wdata_i[LEN_W-1:0];
        CFG_MAX_COMMAND:   max_command_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame fields, checksum and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q      <= '0;
      frame_length_q  <= '0;
      frame_status_q  <= '0;
      param_counter_q <= '0;
      running_sum_q   <= '0;
      emit_idx_q      <= '0;
    end else begin
      if (cmd_i.load_id) begin
        frame_id_q    <= rx_byte_i;
        running_sum_q <= rx_byte_i;
      end
      if (cmd_i.load_len) begin
        frame_length_q <= rx_byte_i[LEN_W-1:0];
        running_sum_q  <= running_sum_q + rx_byte_i;
      end
      if (cmd_i.load_cmd) begin
        frame_status_q  <= rx_byte_i;
        running_sum_q   <= running_sum_q + rx_byte_i;
        param_counter_q <= '0;
      end
      if (cmd_i.store_param) begin
        param_counter_q <= param_counter_q + LEN_W'(1);
        running_sum_q   <= running_sum_q + rx_byte_i;
      end
      if (cmd_i.start_emit) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        emit_idx_q <= emit_idx_q + LEN_W'(1);
      end
    end
  end

  // Parameter store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_param) begin
      store_mem[param_counter_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    rd_data_q <= store_mem[emit_idx_q[ADDR_W-1:0]];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      src_id_o      <= frame_id_q;
      status_byte_o <= frame_status_q;
      param_count_o <= has_params ? count_w : '0;
      has_param_o   <= has_params;
      param_index_o <= has_params ? emit_idx_q[IDX_OUT_W-1:0] : '0;
      param_value_o <= has_params ? rd_data_q : '0;
      last_o        <= status_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/servo_reply_frame_parser_core.sv -----
// Servo reply frame parser: top level joining controller and datapath.
//
// Input channel: one bus byte per item on rx_byte_i, in_valid_i/in_stall_o.
// Output channel: one result per parameter byte of a good frame (or one
// empty result), out_valid_o/out_stall_i with the frame fields on ports.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i.
// Bytes are taken without stalling while the parser hunts or collects a frame.
// After the checksum byte of a good frame the input stalls while the run is
// emitted: each parameter result goes through a store read state and then a
// load state; the one result of an empty frame needs only the load state.
// The input reopens once the last result of the run is in the output register,
// so the next frame may arrive while it waits.
// If the receiver stalls, the output register holds its item and the run
// pauses until it is taken.
// Reset returns to header hunting, loads the register reset values and
// clears the output valid; the parameter store needs no clearing.
`default_nettype none

module servo_reply_frame_parser_core #(
  parameter int unsigned MAX_PARAMS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [srfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [srfp_pkg::BYTE_W-1:0]     cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [srfp_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [srfp_pkg::BYTE_W-1:0]          src_id_o,
  output logic [srfp_pkg::BYTE_W-1:0]          status_byte_o,
  output logic [srfp_pkg::LEN_W-1:0]           param_count_o,
  output logic                                 has_param_o,
  output logic [srfp_pkg::IDX_OUT_W-1:0]       param_index_o,
  output logic [srfp_pkg::BYTE_W-1:0]          param_value_o,
  output logic                                 last_o
);
  import srfp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  srfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srfp_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .src_id_o      (src_id_o),
    .status_byte_o (status_byte_o),
    .param_count_o (param_count_o),
    .has_param_o   (has_param_o),
    .param_index_o (param_index_o),
    .param_value_o (param_value_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/srfp_checker.sv -----
// Port-level checker for the servo reply frame parser, bound to the top level.
`default_nettype none
`include "servo_reply_frame_parser_core_defines.svh"

module srfp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [srfp_pkg::LEN_W-1:0]      param_count_o,
  input wire logic                            has_param_o,
  input wire logic [srfp_pkg::IDX_OUT_W-1:0]  param_index_o,
  input wire logic [srfp_pkg::BYTE_W-1:0]     param_value_o,
  input wire logic                            last_o
);
  import srfp_pkg::*;

  logic [LEN_W-1:0] idx_next;
  assign idx_next = {1'b0, param_index_o} + LEN_W'(1);

  `SRFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(param_value_o) && $stable(last_o))
  `SRFP_ASSERT_NOW(a_empty_shape, clk_i, rst_ni, out_valid_o && !has_param_o, last_o && (param_count_o == '0) && (param_value_o == '0))
  `SRFP_ASSERT_NOW(a_index_range, clk_i, rst_ni, out_valid_o && has_param_o, idx_next <= param_count_o)
  `SRFP_ASSERT_NOW(a_last_at_end, clk_i, rst_ni, out_valid_o && has_param_o, last_o == (idx_next == param_count_o))

endmodule

bind servo_reply_frame_parser_core srfp_checker u_srfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .param_count_o (param_count_o),
  .has_param_o   (has_param_o),
  .param_index_o (param_index_o),
  .param_value_o (param_value_o),
  .last_o        (last_o)
);

`default_nettype wire
